// ===== hw/rtl/affw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affw_pkg
// Shared types and constants for the affine inverse warp sampler.
// ----------------------------------------------------------------------------
package affw_pkg;

  localparam int MAX_SRC_DIM_DEF = 256;
  localparam int CHANNELS_DEF    = 4;

  localparam int POS_W   = 12;
  localparam int PIX_W   = 32;
  localparam int COEF_W  = 32;
  localparam int DIM_W   = 9;
  localparam int INDEX_W = 3;
  localparam int DATA_W  = 32;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd65536;
  localparam logic [DIM_W-1:0]         DIM_RESET = 9'd256;

  typedef enum logic [INDEX_W-1:0] {
    REG_COEF_XX    = 3'd0,
    REG_COEF_XY    = 3'd1,
    REG_OFFSET_X   = 3'd2,
    REG_COEF_YX    = 3'd3,
    REG_COEF_YY    = 3'd4,
    REG_OFFSET_Y   = 3'd5,
    REG_SRC_WIDTH  = 3'd6,
    REG_SRC_HEIGHT = 3'd7
  } affw_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } affw_action_t;

  typedef struct packed {
    logic             action;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel_in;
  } affw_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             inside_res;
  } affw_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MUL,
    ST_ADD,
    ST_CHECK,
    ST_READ,
    ST_OUT
  } affw_state_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic mul;
    logic add;
    logic check;
    logic read;
  } affw_cmd_t;

endpackage

// ===== hw/rtl/affw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affw_ctrl
// Sequencer: capture, then write (load) or map, bounds check, read (query).
// ----------------------------------------------------------------------------
module affw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               action,
  output logic               busy,
  output logic               done,
  output affw_pkg::affw_cmd_t cmd
);
  import affw_pkg::*;

  affw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (action == ACT_QUERY) ? ST_MUL : ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_MUL:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_CHECK;
      ST_CHECK: state_next = ST_READ;
      ST_READ:  state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_WRITE: cmd.write = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_ADD:   cmd.add   = 1'b1;
      ST_CHECK: cmd.check = 1'b1;
      ST_READ:  cmd.read  = 1'b1;
      ST_OUT:   done      = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  a_query_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_QUERY) |-> ##5 done)
    else $error("query result not delivered five cycles after accept");

  a_load_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_LOAD) |=> (busy && !done) ##1 !busy)
    else $error("load request did not complete in two cycles");

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("sequencer did not return to idle after result");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && $past(cmd.read))
    else $error("result strobe without preceding frame read");

endmodule

// ===== hw/rtl/affw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affw_dp
// Datapath: config registers, affine mapping, bounds check, frame store.
// ----------------------------------------------------------------------------
module affw_dp #(
  parameter int MAX_SRC_DIM = affw_pkg::MAX_SRC_DIM_DEF,
  parameter int CHANNELS    = affw_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  affw_pkg::affw_cmd_t           cmd,
  input  affw_pkg::affw_req_t           req,
  input  logic                          wr_en,
  input  logic [affw_pkg::INDEX_W-1:0]  wr_index,
  input  logic [affw_pkg::DATA_W-1:0]   wr_data,
  output affw_pkg::affw_res_t           res
);
  import affw_pkg::*;

  localparam int AW     = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1;
  localparam int DEPTH  = 1 << (2 * AW);
  localparam int LIM_W  = POS_W + 1;
  localparam int PROD_W = COEF_W + POS_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int INT_W  = SUM_W - 16;
  localparam logic [PIX_W-1:0]  ChMask = PIX_W'((64'd1 << (8 * CHANNELS)) - 64'd1);
  localparam logic [LIM_W-1:0]  MaxDim = LIM_W'(MAX_SRC_DIM);

  // configuration
  logic signed [COEF_W-1:0] coef_xx, coef_xy, offset_x;
  logic signed [COEF_W-1:0] coef_yx, coef_yy, offset_y;
  logic [DIM_W-1:0]         src_width, src_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xx    <= COEF_ONE;
      coef_xy    <= '0;
      offset_x   <= '0;
      coef_yx    <= '0;
      coef_yy    <= COEF_ONE;
      offset_y   <= '0;
      src_width  <= DIM_RESET;
      src_height <= DIM_RESET;
    end else if (wr_en) begin
      case (affw_reg_t'(wr_index))
        REG_COEF_XX:    coef_xx    <= wr_data;
        REG_COEF_XY:    coef_xy    <= wr_data;
        REG_OFFSET_X:   offset_x   <= wr_data;
        REG_COEF_YX:    coef_yx    <= wr_data;
        REG_COEF_YY:    coef_yy    <= wr_data;
        REG_OFFSET_Y:   offset_y   <= wr_data;
        REG_SRC_WIDTH:  src_width  <= wr_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= wr_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [POS_W-1:0] pos_x, pos_y;
  logic [PIX_W-1:0] pixel_in;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_x    <= req.pos_x;
      pos_y    <= req.pos_y;
      pixel_in <= req.pixel_in;
    end
  end

  // products, one register stage
  logic signed [POS_W:0]    px_s, py_s;
  logic signed [PROD_W-1:0] prod_xx, prod_xy, prod_yx, prod_yy;

  assign px_s = {1'b0, pos_x};
  assign py_s = {1'b0, pos_y};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_xx <= PROD_W'(coef_xx) * PROD_W'(px_s);
      prod_xy <= PROD_W'(coef_xy) * PROD_W'(py_s);
      prod_yx <= PROD_W'(coef_yx) * PROD_W'(px_s);
      prod_yy <= PROD_W'(coef_yy) * PROD_W'(py_s);
    end
  end

  // Q30.16 sums
  logic signed [SUM_W-1:0] sum_x, sum_y;

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      sum_x <= SUM_W'(prod_xx) + SUM_W'(prod_xy) + SUM_W'(offset_x);
      sum_y <= SUM_W'(prod_yx) + SUM_W'(prod_yy) + SUM_W'(offset_y);
    end
  end

  // truncate toward zero: floor, plus one for negative values with a fraction
  logic [INT_W-1:0] col, row, frow;
  logic [LIM_W-1:0] eff_w, eff_h;
  logic             in_x, in_y;

  always_comb begin
    col   = sum_x[SUM_W-1:16] + INT_W'(sum_x[SUM_W-1] && (sum_x[15:0] != 16'd0));
    row   = sum_y[SUM_W-1:16] + INT_W'(sum_y[SUM_W-1] && (sum_y[15:0] != 16'd0));
    eff_w = (LIM_W'(src_width) > MaxDim) ? MaxDim : LIM_W'(src_width);
    eff_h = (LIM_W'(src_height) > MaxDim) ? MaxDim : LIM_W'(src_height);
    in_x  = !col[INT_W-1] && (col < INT_W'(eff_w));
    in_y  = !row[INT_W-1] && (row < INT_W'(eff_h));
    frow  = INT_W'(eff_h) - INT_W'(1) - row;
  end

  logic [2*AW-1:0] rd_addr;
  logic            in_bounds;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      rd_addr   <= {frow[AW-1:0], col[AW-1:0]};
      in_bounds <= in_x && in_y;
    end
  end

  // frame store
  logic [PIX_W-1:0] frame [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic             load_ok;

  assign load_ok = (LIM_W'(pos_x) < MaxDim) && (LIM_W'(pos_y) < MaxDim);

  always_ff @(posedge clk) begin
    if (cmd.write && load_ok) begin
      frame[{pos_y[AW-1:0], pos_x[AW-1:0]}] <= pixel_in;
    end
    if (cmd.read) begin
      rd_data <= frame[rd_addr];
    end
  end

  assign res.pixel_out  = in_bounds ? (rd_data & ChMask) : '0;
  assign res.inside_res = in_bounds;

endmodule

// ===== hw/rtl/affine_inverse_warp_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_inverse_warp_sampler
// Nearest-neighbor affine inverse mapping into a source frame store.
// ----------------------------------------------------------------------------
// query: result strobe after the multiply, add, bounds check and frame read stages in series;
//   busy holds off a new request until the result has been delivered
// load: written in the cycle after accept; busy until the write is done
// results cannot be stalled; done is high for exactly one cycle
// reset clears the sequencer and config registers; frame store is not cleared
module affine_inverse_warp_sampler #(
  parameter int MAX_SRC_DIM = affw_pkg::MAX_SRC_DIM_DEF,
  parameter int CHANNELS    = affw_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  affw_pkg::affw_req_t          req,
  output logic                         done,
  output affw_pkg::affw_res_t          res,
  input  logic                         wr_en,
  input  logic [affw_pkg::INDEX_W-1:0] wr_index,
  input  logic [affw_pkg::DATA_W-1:0]  wr_data
);
  import affw_pkg::*;

  affw_cmd_t cmd;

  affw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (req.action),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  affw_dp #(
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .res      (res)
  );

endmodule
